/* src/touch_bar_gesture_classifier_assert.svh */
// assertion macros used by the checker file
`ifndef TOUCH_BAR_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_BAR_GESTURE_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TBGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TBGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tbgc_pkg.sv */
// shared types, codes and widths of the touch bar gesture classifier
package tbgc_pkg;

  localparam int NUM_CH    = 3;
  localparam int DEFL_W    = 16;
  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int DOM_W     = 8;
  localparam int KIND_W    = 3;
  localparam int ACT_W     = 3;
  localparam int ZONE_W    = 2;
  localparam int MAX_ITEMS = 256;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;

  // event kinds
  localparam logic [KIND_W-1:0] EV_NONE      = 3'd0;
  localparam logic [KIND_W-1:0] EV_SWIPE_NEG = 3'd1;
  localparam logic [KIND_W-1:0] EV_FLICK_NEG = 3'd2;
  localparam logic [KIND_W-1:0] EV_SWIPE_POS = 3'd3;
  localparam logic [KIND_W-1:0] EV_FLICK_POS = 3'd4;
  localparam logic [KIND_W-1:0] EV_TAP       = 3'd5;
  localparam logic [KIND_W-1:0] EV_HOLD      = 3'd6;

  // actions
  localparam logic [ACT_W-1:0] ACT_NONE        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ITEM        = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TIMER       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_HOLD_MIDDLE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_HOLD_RIGHT  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_HOLD_LEFT   = 3'd5;

  // zones
  localparam logic [ZONE_W-1:0] ZONE_LEFT   = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_MIDDLE = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_RIGHT  = 2'd2;
  localparam logic [ZONE_W-1:0] ZONE_NONE   = 2'd3;

  // configuration register indexes
  localparam logic CFG_ITEM_COUNT = 1'b0;
  localparam logic CFG_DOMINANCE  = 1'b1;

  typedef logic [DEFL_W-1:0] defl_t;
  typedef logic [NUM_CH-1:0][DEFL_W-1:0] defl_vec_t;

  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } pipe_ctl_t;

endpackage

/* src/tbgc_lane.sv */
// one channel lane: clamped deflection and touch flag, registered
module tbgc_lane (
  input  logic               clk,
  input  tbgc_pkg::pipe_ctl_t ctl,
  input  tbgc_pkg::defl_t    baseline,
  input  tbgc_pkg::defl_t    count,
  input  logic               touch,
  output tbgc_pkg::defl_t    defl_r,
  output logic               touch_r
);
  import tbgc_pkg::*;

  defl_t defl_nxt;

  always_comb begin
    defl_nxt = (baseline > count) ? defl_t'(baseline - count) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      defl_r  <= defl_nxt;
      touch_r <= touch;
    end
  end

endmodule

/* src/tbgc_index.sv */
// selected item state, wrap stepping and remainder pass after a count write
module tbgc_index (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [tbgc_pkg::KIND_W-1:0] kind,
  input  logic                       start,
  input  logic [tbgc_pkg::CNT_W-1:0] count_raw,
  output logic [tbgc_pkg::IDX_W-1:0] idx_new,
  output logic                       rdy
);
  import tbgc_pkg::*;

  logic [IDX_W-1:0] sel_r;
  logic [IDX_W-1:0] red_r;
  logic [IDX_W-1:0] rem_r;
  logic [2:0]       bit_r;
  logic             busy_r;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] inc;
  logic [CNT_W-1:0] n_m1;
  logic [IDX_W-1:0] up_val;
  logic [IDX_W-1:0] dn_val;
  logic             up;
  logic             dn;
  logic [CNT_W-1:0] rem_sh;
  logic [CNT_W-1:0] rem_nxt;

  always_comb begin
    priority if (count_raw == '0) n_eff = CNT_W'(1);
    else if (count_raw > CNT_W'(MAX_ITEMS)) n_eff = CNT_W'(MAX_ITEMS);
    else n_eff = count_raw;
  end

  always_comb begin
    up     = (kind == EV_SWIPE_POS) || (kind == EV_FLICK_POS);
    dn     = (kind == EV_SWIPE_NEG) || (kind == EV_FLICK_NEG);
    inc    = {1'b0, red_r} + CNT_W'(1);
    n_m1   = n_eff - CNT_W'(1);
    up_val = (inc == n_eff) ? '0 : inc[IDX_W-1:0];
    dn_val = (red_r == '0) ? n_m1[IDX_W-1:0] : red_r - IDX_W'(1);
    priority if (up) idx_new = up_val;
    else if (dn) idx_new = dn_val;
    else idx_new = sel_r;
  end

  // restoring remainder, one bit of the stored index per cycle
  always_comb begin
    rem_sh  = {rem_r, sel_r[bit_r]};
    rem_nxt = (rem_sh >= n_eff) ? rem_sh - n_eff : rem_sh;
  end

  assign rdy = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r  <= '0;
      red_r  <= '0;
      rem_r  <= '0;
      bit_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= 3'd7;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt[IDX_W-1:0];
        bit_r <= bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          busy_r <= 1'b0;
          red_r  <= rem_nxt[IDX_W-1:0];
        end
      end
      if (step_en && (up || dn)) begin
        sel_r <= idx_new;
        red_r <= idx_new;
      end
    end
  end

endmodule

/* src/tbgc_merge.sv */
// merges the lanes: winner and runner-up, then the dominance ratio test
module tbgc_merge (
  input  logic                        clk,
  input  tbgc_pkg::pipe_ctl_t         ctl,
  input  tbgc_pkg::defl_vec_t         defl,
  input  logic [tbgc_pkg::NUM_CH-1:0] touched,
  input  logic                        hold,
  input  logic [tbgc_pkg::ACT_W-1:0]  act_in,
  input  logic [tbgc_pkg::IDX_W-1:0]  idx_in,
  input  logic [tbgc_pkg::DOM_W-1:0]  dominance,
  output logic [tbgc_pkg::ACT_W-1:0]  action_r,
  output logic [tbgc_pkg::IDX_W-1:0]  idx_r,
  output logic [tbgc_pkg::ZONE_W-1:0] zone_r,
  output tbgc_pkg::defl_t             wdef_r,
  output tbgc_pkg::defl_t             rdef_r,
  output logic                        dom_r
);
  import tbgc_pkg::*;

  localparam int PROD_W = DEFL_W + DOM_W;

  logic [ACT_W-1:0]  act2_r;
  logic [IDX_W-1:0]  idx2_r;
  logic [ZONE_W-1:0] zone2_r;
  defl_t             wdef2_r;
  defl_t             rdef2_r;

  logic [ZONE_W-1:0] zone_nxt;
  defl_t             wdef_nxt;
  defl_t             rdef_nxt;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] prod;
  logic              pass;
  logic [ACT_W-1:0]  act3_nxt;

  // winner: strictly larger touched deflection, lower channel keeps a tie
  always_comb begin
    zone_nxt = ZONE_NONE;
    wdef_nxt = '0;
    rdef_nxt = '0;
    if (hold) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (touched[i] && (defl[i] > wdef_nxt)) begin
          wdef_nxt = defl[i];
          zone_nxt = ZONE_W'(i);
        end
      end
      for (int i = 0; i < NUM_CH; i++) begin
        if ((zone_nxt != ZONE_W'(i)) && (defl[i] > rdef_nxt)) begin
          rdef_nxt = defl[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      act2_r  <= act_in;
      idx2_r  <= idx_in;
      zone2_r <= zone_nxt;
      wdef2_r <= wdef_nxt;
      rdef2_r <= rdef_nxt;
    end
  end

  always_comb begin
    lhs  = {{(PROD_W-DEFL_W-3){1'b0}}, wdef2_r, 3'b000};
    prod = rdef2_r * dominance;
    pass = (zone2_r != ZONE_NONE) && (lhs >= prod);
    act3_nxt = act2_r;
    if (pass) begin
      unique case (zone2_r)
        ZONE_LEFT:   act3_nxt = ACT_HOLD_LEFT;
        ZONE_MIDDLE: act3_nxt = ACT_HOLD_MIDDLE;
        ZONE_RIGHT:  act3_nxt = ACT_HOLD_RIGHT;
        default:     act3_nxt = act2_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      action_r <= act3_nxt;
      idx_r    <= idx2_r;
      zone_r   <= zone2_r;
      wdef_r   <= wdef2_r;
      rdef_r   <= rdef2_r;
      dom_r    <= pass;
    end
  end

endmodule

/* src/touch_bar_gesture_classifier.sv */
// touch bar gesture classifier top level
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------
//   in       | in  | in_tvalid/tready   | tdata: channel counts, tuser: kind
//   out      | out | out_tvalid/tready  | tdata: index, zone, deflections
//   cfg      | in  | cfg_we             | cfg_addr, cfg_wdata
//
// one word per cycle unless the output stalls or a remainder pass runs; each
// word goes through lane deflection, winner merge, 16x8 dominance multiply, compare
// rst_n clears the stored index and all valid flags, sets item_count to 8 and dominance to 12
// a write to item_count starts a remainder pass on the stored index;
// no word is taken during it
// a stalled output holds the pipeline behind it; stages fill in while it waits
module touch_bar_gesture_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // baseline_a, baseline_b, baseline_c, count_a, count_b, count_c,
  // touch_a, touch_b, touch_c, zero pad
  input  logic [tbgc_pkg::IN_DATA_W-1:0]      in_tdata,
  // event_kind
  input  logic [tbgc_pkg::KIND_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // item_index, winning_zone, winner_deflection, runner_up_deflection,
  // dominant, zero pad
  output logic [tbgc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // action
  output logic [tbgc_pkg::ACT_W-1:0]          out_tuser,
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [tbgc_pkg::CNT_W-1:0]          cfg_wdata
);
  import tbgc_pkg::*;

  logic [CNT_W-1:0] item_count_r;
  logic [DOM_W-1:0] dominance_r;

  logic v1_r;
  logic v2_r;
  logic v3_r;
  pipe_ctl_t ctl;

  logic             idx_rdy;
  logic [IDX_W-1:0] idx_new;
  logic             hold1_r;
  logic [ACT_W-1:0] act1_r;
  logic [IDX_W-1:0] idx1_r;
  logic [ACT_W-1:0] act_nxt;

  defl_t             base [NUM_CH];
  defl_t             cnt  [NUM_CH];
  logic [NUM_CH-1:0] touch;
  defl_vec_t         defl;
  logic [NUM_CH-1:0] touched;

  logic [ACT_W-1:0]  action;
  logic [IDX_W-1:0]  idx_out;
  logic [ZONE_W-1:0] zone;
  defl_t             wdef;
  defl_t             rdef;
  logic              dom;

  // pipeline control
  always_comb begin
    ctl.adv3  = v2_r && (!v3_r || out_tready);
    ctl.adv2  = v1_r && (!v2_r || ctl.adv3);
    in_tready = idx_rdy && (!v1_r || ctl.adv2);
    ctl.adv1  = in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      item_count_r <= CNT_W'(8);
      dominance_r  <= DOM_W'(12);
    end else begin
      if (ctl.adv1) v1_r <= 1'b1;
      else if (ctl.adv2) v1_r <= 1'b0;
      if (ctl.adv2) v2_r <= 1'b1;
      else if (ctl.adv3) v2_r <= 1'b0;
      if (ctl.adv3) v3_r <= 1'b1;
      else if (out_tready) v3_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_ITEM_COUNT: item_count_r <= cfg_wdata;
          CFG_DOMINANCE:  dominance_r  <= cfg_wdata[DOM_W-1:0];
          default:        dominance_r  <= dominance_r;
        endcase
      end
    end
  end

  tbgc_index u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (ctl.adv1),
    .kind      (in_tuser),
    .start     (cfg_we && (cfg_addr == CFG_ITEM_COUNT)),
    .count_raw (item_count_r),
    .idx_new   (idx_new),
    .rdy       (idx_rdy)
  );

  always_comb begin
    unique case (in_tuser)
      EV_SWIPE_NEG, EV_FLICK_NEG, EV_SWIPE_POS, EV_FLICK_POS: act_nxt = ACT_ITEM;
      EV_TAP:  act_nxt = ACT_TIMER;
      default: act_nxt = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      hold1_r <= (in_tuser == EV_HOLD);
      act1_r  <= act_nxt;
      idx1_r  <= idx_new;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      base[i]  = in_tdata[i*DEFL_W +: DEFL_W];
      cnt[i]   = in_tdata[(NUM_CH+i)*DEFL_W +: DEFL_W];
      touch[i] = in_tdata[2*NUM_CH*DEFL_W + i];
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    tbgc_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .baseline (base[g]),
      .count    (cnt[g]),
      .touch    (touch[g]),
      .defl_r   (defl[g]),
      .touch_r  (touched[g])
    );
  end

  tbgc_merge u_merge (
    .clk       (clk),
    .ctl       (ctl),
    .defl      (defl),
    .touched   (touched),
    .hold      (hold1_r),
    .act_in    (act1_r),
    .idx_in    (idx1_r),
    .dominance (dominance_r),
    .action_r  (action),
    .idx_r     (idx_out),
    .zone_r    (zone),
    .wdef_r    (wdef),
    .rdef_r    (rdef),
    .dom_r     (dom)
  );

  assign out_tvalid = v3_r;
  assign out_tuser  = action;
  assign out_tdata  = {5'b0, dom, rdef, wdef, zone, idx_out};

endmodule

/* src/tbgc_checker.sv */
// port checker for the touch bar gesture classifier, bound to the top level
`include "touch_bar_gesture_classifier_assert.svh"

module tbgc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tbgc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [tbgc_pkg::ACT_W-1:0]      out_tuser
);
  import tbgc_pkg::*;

  `TBGC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "output word changed while stalled")

  `TBGC_ASSERT_IMP(a_no_zone, out_tvalid && (out_tdata[9:8] == ZONE_NONE), !out_tdata[42] && (out_tdata[25:10] == 16'd0), "no winner but dominant or nonzero winner deflection")

  `TBGC_ASSERT_IMP(a_hold_dom, out_tvalid && ((out_tuser == ACT_HOLD_LEFT) || (out_tuser == ACT_HOLD_MIDDLE) || (out_tuser == ACT_HOLD_RIGHT)), out_tdata[42], "hold action without dominance")

  `TBGC_ASSERT_IMP(a_dom_zone, out_tvalid && out_tdata[42], ((out_tdata[9:8] == ZONE_LEFT) && (out_tuser == ACT_HOLD_LEFT)) || ((out_tdata[9:8] == ZONE_MIDDLE) && (out_tuser == ACT_HOLD_MIDDLE)) || ((out_tdata[9:8] == ZONE_RIGHT) && (out_tuser == ACT_HOLD_RIGHT)), "dominant hold action does not match zone")

endmodule

bind touch_bar_gesture_classifier tbgc_checker u_tbgc_checker (.*);
